// ===== rtl/core/modular_inverse_core_defines.svh =====
// Assertion macros for the modular inverse core.
// Used by modular_inverse_core; relies on clk and arst_n in the including module.
`ifndef MODULAR_INVERSE_CORE_DEFINES_SVH
`define MODULAR_INVERSE_CORE_DEFINES_SVH

// Check a same-cycle implication.
`define MI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication on the next cycle.
`define MI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/modinv_pkg.sv =====
// Shared constants for the modular inverse core.
// No dependencies; imported by modinv_divu, modular_inverse_core and tb_top.
`timescale 1ns / 1ps

package modinv_pkg;

	localparam int DATA_W        = 32;
	localparam int WIDTH_DEF     = 32;
	localparam int MAX_STEPS_DEF = 50;
	localparam int CNT_MIN_W     = 1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

endpackage

// ===== rtl/core/modinv_divu.sv =====
// Bit-serial restoring divider with a shift-add multiply of the quotient.
// Depends on modinv_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps

module modinv_divu
	import modinv_pkg::*;
#(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	input  logic [WIDTH-1:0] mult,
	output logic             busy,
	output logic             done,
	output logic [WIDTH-1:0] rem,
	output logic [WIDTH:0]   prod
);

	localparam int CNT_W = ($clog2(WIDTH + 1) > CNT_MIN_W) ? $clog2(WIDTH + 1) : CNT_MIN_W;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] d_q;
	logic [WIDTH-1:0] mc_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH:0]   acc_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;
	logic [WIDTH:0]   acc_next;

	assign trial    = {rem_q, n_q[WIDTH-1]};
	assign ge       = trial >= {1'b0, d_q};
	assign diff     = trial - {1'b0, d_q};
	assign acc_next = {acc_q[WIDTH-1:0], 1'b0} + (ge ? {1'b0, mc_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			d_q   <= divisor;
			mc_q  <= mult;
			rem_q <= '0;
			acc_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[WIDTH-2:0], 1'b0};
			rem_q <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			acc_q <= acc_next;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;
	assign prod = acc_q;

endmodule

// ===== rtl/core/modular_inverse_core.sv =====
// Modular inverse by extended Euclid: one divide per Euclid step.
// Steps are bounded by MAX_STEPS; the single serial divider is shared by every step.
// Flow: one item at a time; s_tready is high only in idle.
// Reset: arst_n clears the sequencer and the output valid asynchronously.
`timescale 1ns / 1ps
`include "modular_inverse_core_defines.svh"

module modular_inverse_core
	import modinv_pkg::*;
#(
	parameter int WIDTH     = WIDTH_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*DATA_W-1:0] s_tdata,  // value, modulus
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [DATA_W-1:0]   m_tdata,  // inverse
	output logic [0:0]          m_tuser   // status
);

	localparam int STEP_W = $clog2(MAX_STEPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LAUNCH,
		ST_WAIT,
		ST_FIN1,
		ST_FIN2,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic              red_q;
	logic [STEP_W-1:0] step_q;
	logic [WIDTH-1:0]  m_q;
	logic [WIDTH-1:0]  r_old_q;
	logic [WIDTH-1:0]  r_cur_q;
	logic [WIDTH-1:0]  c_old_q;
	logic [WIDTH-1:0]  c_cur_q;
	logic [WIDTH:0]    c_new_q;
	logic [WIDTH-1:0]  res_q;
	logic              err_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              m_tuser_q;

	logic [DATA_W+WIDTH-1:0] v_ext;
	logic [DATA_W+WIDTH-1:0] m_ext;
	logic [DATA_W+WIDTH-1:0] res_ext;
	logic                    div_start;
	logic                    div_busy;
	logic                    div_done;
	logic [WIDTH-1:0]        div_rem;
	logic [WIDTH:0]          div_prod;
	logic [WIDTH:0]          c_new;
	logic [WIDTH:0]          c_red;

	assign v_ext   = {{WIDTH{1'b0}}, s_tdata[DATA_W-1:0]};
	assign m_ext   = {{WIDTH{1'b0}}, s_tdata[2*DATA_W-1:DATA_W]};
	assign res_ext = {{DATA_W{1'b0}}, res_q};

	assign div_start = (state_q == ST_LAUNCH);
	assign c_new     = {1'b0, c_old_q} + div_prod;
	assign c_red     = (c_new_q >= {1'b0, m_q}) ? (c_new_q - {1'b0, m_q}) : c_new_q;

	modinv_divu #(
		.WIDTH(WIDTH)
	) u_divu (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(r_old_q),
		.divisor (r_cur_q),
		.mult    (c_cur_q),
		.busy    (div_busy),
		.done    (div_done),
		.rem     (div_rem),
		.prod    (div_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			red_q      <= 1'b0;
			step_q     <= '0;
			err_q      <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						r_old_q <= v_ext[WIDTH-1:0];
						r_cur_q <= m_ext[WIDTH-1:0];
						m_q     <= m_ext[WIDTH-1:0];
						c_old_q <= '0;
						c_cur_q <= '0;
						red_q   <= 1'b1;
						step_q  <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (m_q < WIDTH'(2)) begin
						res_q   <= '0;
						err_q   <= STATUS_ERR;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						if (div_rem == '0) begin
							res_q   <= '0;
							err_q   <= STATUS_ERR;
							state_q <= ST_OUT;
						end else if (red_q) begin
							if (div_rem == WIDTH'(1)) begin
								res_q   <= WIDTH'(1);
								err_q   <= STATUS_OK;
								state_q <= ST_OUT;
							end else begin
								r_old_q <= m_q;
								r_cur_q <= div_rem;
								c_old_q <= '0;
								c_cur_q <= WIDTH'(1);
								step_q  <= STEP_W'(1);
								red_q   <= 1'b0;
								state_q <= ST_LAUNCH;
							end
						end else if (div_rem == WIDTH'(1)) begin
							c_new_q <= c_new;
							state_q <= ST_FIN1;
						end else if (step_q == STEP_W'(MAX_STEPS)) begin
							res_q   <= '0;
							err_q   <= STATUS_ERR;
							state_q <= ST_OUT;
						end else begin
							r_old_q <= r_cur_q;
							r_cur_q <= div_rem;
							c_old_q <= c_cur_q;
							c_cur_q <= c_new[WIDTH-1:0];
							step_q  <= step_q + 1'b1;
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_FIN1: begin
					res_q   <= c_red[WIDTH-1:0];
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					// odd step count: coefficient is negative, fold into range
					if (step_q[0] && res_q != '0) begin
						res_q <= m_q - res_q;
					end
					err_q   <= STATUS_OK;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_ext[DATA_W-1:0];
						m_tuser_q  <= err_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	`MI_ASSERT_NOW(a_idle_div_quiet, state_q == ST_IDLE, !div_busy && !div_done,
		"divider active while idle")
	`MI_ASSERT_NOW(a_done_in_wait, div_done, state_q == ST_WAIT,
		"divide finished outside wait state")
	`MI_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser[0] == STATUS_ERR, m_tdata == '0,
		"error result carries nonzero inverse")
	`MI_ASSERT_NOW(a_step_bound, 1'b1, step_q <= STEP_W'(MAX_STEPS),
		"step counter beyond limit")
	`MI_ASSERT_NEXT(a_launch_busy, state_q == ST_LAUNCH, div_busy,
		"divider did not start on launch")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for modular_inverse_core: directed table, then random pairs.
// Expected beats: table rows or an extended-Euclid predictor; needs only modinv_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
	import modinv_pkg::*;

	localparam int TB_MAX_STEPS = MAX_STEPS_DEF;
	localparam int RAND_ITEMS   = 350;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 4000;
	localparam int DRAIN_CYCLES = 2000;
	localparam int LIMIT_CYCLES = 3000000;

	typedef struct packed {
		logic [DATA_W-1:0] inverse;
		logic              status;
	} inv_result_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] modulus;
		bit                typed;
		inv_result_t       want;
	} inv_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [2*DATA_W-1:0] s_tdata  = '0;  // value, modulus
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;        // inverse
	logic [0:0]          m_tuser;        // status

	inv_row_t    items[$];
	inv_result_t inverse_due[$];
	int          n_results   = 0;
	int          n_errors    = 0;
	bit          sender_done = 1'b0;
	logic        quiet;

	assign quiet = (n_results >= 150) && (n_results < 200);

	modular_inverse_core #(
		.WIDTH    (DATA_W),
		.MAX_STEPS(TB_MAX_STEPS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic inv_result_t inverse_mod(input logic [DATA_W-1:0] value,
			input logic [DATA_W-1:0] modulus);
		inv_result_t res;
		logic [63:0] m64, r_old, r_cur, c_old, c_cur, quo, rem, c_new, fin;
		int          step;
		res.inverse = '0;
		res.status  = STATUS_ERR;
		m64         = {32'd0, modulus};
		if (m64 < 2)
			return res;
		r_cur = {32'd0, value} % m64;
		if (r_cur == 0)
			return res;
		if (r_cur == 1) begin
			res.inverse = 1;
			res.status  = STATUS_OK;
			return res;
		end
		r_old = m64;
		c_old = 0;
		c_cur = 1;
		for (step = 1; step <= TB_MAX_STEPS; step++) begin
			quo   = r_old / r_cur;
			rem   = r_old % r_cur;
			c_new = c_old + quo * c_cur;
			if (rem == 0)
				return res;
			if (rem == 1) begin
				fin = c_new % m64;
				// odd step count leaves the coefficient negative
				if (step % 2 == 1)
					fin = m64 - fin;
				if (fin == m64)
					fin = 0;
				res.inverse = fin[DATA_W-1:0];
				res.status  = STATUS_OK;
				return res;
			end
			r_old = r_cur;
			r_cur = rem;
			c_old = c_cur;
			c_cur = c_new;
		end
		return res;
	endfunction

	function automatic inv_row_t check_row(input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] m);
		inv_row_t row;
		row.value   = v;
		row.modulus = m;
		row.typed   = 1'b0;
		row.want    = '0;
		return row;
	endfunction

	function automatic inv_row_t known_row(input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] m,
			input logic [DATA_W-1:0] inv, input logic st);
		inv_row_t row;
		row.value        = v;
		row.modulus      = m;
		row.typed        = 1'b1;
		row.want.inverse = inv;
		row.want.status  = st;
		return row;
	endfunction

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [63:0]       fib[0:48];
		logic [DATA_W-1:0] v, m;
		int                i, k, pick;
		fib[0] = 0;
		fib[1] = 1;
		for (i = 2; i <= 48; i++)
			fib[i] = fib[i-1] + fib[i-2];

		items.push_back(known_row(32'd0, 32'd0, 32'd0, STATUS_ERR));
		items.push_back(known_row(32'd5, 32'd1, 32'd0, STATUS_ERR));
		items.push_back(known_row(32'd0, 32'd7, 32'd0, STATUS_ERR));
		items.push_back(known_row(32'd14, 32'd7, 32'd0, STATUS_ERR));
		items.push_back(known_row(32'd1, 32'd7, 32'd1, STATUS_OK));
		items.push_back(known_row(32'd8, 32'd7, 32'd1, STATUS_OK));
		items.push_back(known_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, STATUS_ERR));
		items.push_back(known_row(32'd1, 32'hFFFF_FFFF, 32'd1, STATUS_OK));
		items.push_back(known_row(32'd0, 32'hFFFF_FFFF, 32'd0, STATUS_ERR));
		items.push_back(known_row(32'hFFFF_FFFF, 32'd2, 32'd1, STATUS_OK));
		items.push_back(known_row(32'd6, 32'd9, 32'd0, STATUS_ERR));
		items.push_back(known_row(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, STATUS_OK));
		items.push_back(known_row(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1, STATUS_OK));
		items.push_back(known_row(32'd2, 32'd3, 32'd2, STATUS_OK));
		items.push_back(known_row(32'hAAAA_AAAA, 32'h5555_5555, 32'd0, STATUS_ERR));
		items.push_back(known_row(32'h5555_5555, 32'hAAAA_AAAA, 32'd0, STATUS_ERR));
		items.push_back(check_row(fib[43][31:0], fib[44][31:0]));
		items.push_back(check_row(fib[46][31:0], fib[47][31:0]));
		items.push_back(check_row(fib[42][31:0], fib[43][31:0]));
		items.push_back(check_row(32'd3, 32'd7));
		items.push_back(check_row(32'd2, 32'hFFFF_FFFF));
		items.push_back(check_row(32'h8000_0000, 32'hFFFF_FFFF));
		items.push_back(check_row(32'hFFFF_FFFF, 32'h8000_0000));
		items.push_back(check_row(32'h1234_5678, 32'h8765_4321));
		items.push_back(check_row(32'hFFFF_FFFF, 32'hFFFF_FFFB));

		for (i = 0; i < RAND_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			v    = $urandom;
			m    = $urandom;
			if (pick < 15) begin
				m = $urandom_range(0, 300);
			end else if (pick < 25) begin
				v = $urandom_range(0, 300);
			end else if (pick < 35) begin
				case ($urandom_range(0, 2))
					0: v = m * $urandom_range(0, 3);
					1: v = m * $urandom_range(0, 3) + 1;
					default: v = m - 1;
				endcase
			end else if (pick < 50) begin
				k = $urandom_range(30, 46);
				v = fib[k][31:0];
				m = fib[k+1][31:0];
				if ($urandom_range(0, 1))
					v = v + m;
			end
			items.push_back(check_row(v, m));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (sender_done);
		while (inverse_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// source side: hold each beat until accepted, record its expectation on the handshake
	initial begin
		int idx;
		bit free;
		idx = 0;
		wait (arst_n);
		while (idx < items.size()) begin
			@(posedge clk);
			free = !s_tvalid;
			if (s_tvalid && s_tready) begin
				if (items[idx].typed)
					inverse_due.push_back(items[idx].want);
				else
					inverse_due.push_back(inverse_mod(items[idx].value, items[idx].modulus));
				idx++;
				free = 1'b1;
			end
			if (free) begin
				if (idx < items.size() && (quiet || $urandom_range(0, 99) >= 16)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {items[idx].modulus, items[idx].value};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
		sender_done = 1'b1;
	end

	// sink side: compare each beat with the oldest expectation
	initial begin
		inv_result_t want;
		bit          held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				n_results++;
				if (inverse_due.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected beat: inverse %h status %b", m_tdata, m_tuser[0]);
				end else begin
					want = inverse_due.pop_front();
					if (m_tdata !== want.inverse || m_tuser[0] !== want.status) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch beat %0d: expected inverse %h status %b, got %h %b",
								n_results, want.inverse, want.status, m_tdata, m_tuser[0]);
					end
				end
			end
			if (!held && n_results == HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= quiet || ($urandom_range(0, 99) >= 16);
		end
	end

endmodule
